// ===== sv/zsn_pkg.sv =====
// Shared constants and command/status types for the z-score normalizer.
package zsn_pkg;
    localparam int MAX_SAMPLES = 64;
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = AW + 1;

    localparam logic [3:0] C_NONE  = 4'd0;
    localparam logic [3:0] C_MEAN  = 4'd1;
    localparam logic [3:0] C_SSQ   = 4'd2;
    localparam logic [3:0] C_VAR   = 4'd3;
    localparam logic [3:0] C_SQRT  = 4'd4;
    localparam logic [3:0] C_RD    = 4'd5;
    localparam logic [3:0] C_DIV   = 4'd6;

    typedef struct packed {
        logic          load;
        logic [3:0]    op;
        logic          start;
        logic [AW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic sd_zero;
    } t_stat;
endpackage

// ===== sv/zsn_if.sv =====
// Valid/ready stream interfaces for input and result words.
interface zsn_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        last;
    modport source (output valid, sample, last, input ready);
    modport sink (input valid, sample, last, output ready);
endinterface

interface zsn_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] z_score;
    logic        last_out;
    logic        flat_set;
    logic        saturated;
    modport source (output valid, z_score, last_out, flat_set, saturated, input ready);
    modport sink (input valid, z_score, last_out, flat_set, saturated, output ready);
endinterface

// ===== sv/zsn_datapath.sv =====
// Datapath: sample memory, accumulators and the iterative divide and root units.
module zsn_datapath import zsn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [31:0]       i_sample,
    input  logic [CW-1:0]     i_n,
    output t_stat             o_stat,
    output logic [23:0]       o_z,
    output logic              o_sat
);
    localparam logic [1:0] M_IDLE = 2'd0, M_DIV = 2'd1, M_ROOT = 2'd2, M_ZDIV = 2'd3;

    logic [31:0]  r_mem [MAX_SAMPLES];
    logic [31:0]  r_rd;
    logic signed [37:0] r_sum;
    logic signed [32:0] r_mean;
    logic [69:0]  r_ssq;
    logic [85:0]  r_rem;
    logic [85:0]  r_quo;
    logic [43:0]  r_sd;
    logic [87:0]  r_srem;
    logic [6:0]   r_cnt;
    logic [1:0]   r_mode;
    logic [31:0]  r_mag;
    logic         r_neg;
    logic [67:0]  r_drem;
    logic [56:0]  r_dq;
    logic [63:0]  r_sq;
    logic         r_sqv;

    logic signed [32:0] w_dev;
    logic [32:0]  w_abs;
    logic [86:0]  w_sh;
    logic [89:0]  w_st;
    logic [68:0]  w_dt;
    logic [56:0]  w_lim;
    logic [56:0]  w_m;

    assign w_dev = $signed({r_rd[31], r_rd}) - r_mean;
    assign w_abs = w_dev[32] ? 33'(-w_dev) : 33'(w_dev);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[i_cmd.addr] <= i_sample;
        end
        r_rd <= r_mem[i_cmd.addr];
    end

    assign w_sh  = {r_rem[85:0], r_quo[85]};
    assign w_st  = {r_srem[87:0], r_quo[85:84]};
    assign w_dt  = {r_drem, r_dq[56]};
    assign w_lim = r_neg ? 57'(1 << 23) : 57'((1 << 23) - 1);
    assign w_m   = (r_dq > w_lim) ? w_lim : r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_mode <= M_IDLE;
            r_cnt  <= '0;
            r_sqv  <= 1'b0;
        end else begin
            r_sqv <= 1'b0;
            if (i_cmd.load) begin
                r_sum <= r_sum + 38'($signed(i_sample));
            end
            if (r_sqv) begin
                r_ssq <= r_ssq + 70'(r_sq);
            end
            if (i_cmd.start) begin
                case (i_cmd.op)
                    C_MEAN: begin
                        // Magnitude divide by n, then floor for negatives.
                        r_neg  <= r_sum[37];
                        r_rem  <= '0;
                        r_quo  <= 86'(r_sum[37] ? -r_sum : r_sum) << 48;
                        r_sum  <= '0;
                        r_cnt  <= 7'd38;
                        r_mode <= M_DIV;
                    end
                    C_SSQ: begin
                        r_ssq <= '0;
                    end
                    C_VAR: begin
                        r_rem  <= '0;
                        r_quo  <= {r_ssq, 16'd0};
                        r_cnt  <= 7'd86;
                        r_mode <= M_DIV;
                    end
                    C_SQRT: begin
                        r_srem <= '0;
                        r_sd   <= '0;
                        r_cnt  <= 7'd43;
                        r_mode <= M_ROOT;
                    end
                    C_DIV: begin
                        r_neg  <= w_dev[32];
                        r_drem <= '0;
                        r_dq   <= (57'(w_abs) << 24) + 57'(r_sd >> 1);
                        r_cnt  <= 7'd57;
                        r_mode <= M_ZDIV;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.op == C_SSQ && !i_cmd.start) begin
                r_sq  <= 64'(w_abs[31:0]) * 64'(w_abs[31:0]) +
                         (w_abs[32] ? 64'h0 : 64'h0);
                r_sqv <= 1'b1;
            end
            if (r_mode != M_IDLE && r_cnt == 7'd0) begin
                if (r_mode == M_DIV && i_cmd.op == C_MEAN) begin
                    r_mean <= r_neg ? (r_rem != '0 ? -$signed(33'(r_quo[32:0])) - 33'sd1
                                                    : -$signed(33'(r_quo[32:0])))
                                    : $signed(33'(r_quo[32:0]));
                end
                if (r_mode == M_ZDIV) begin
                    r_mag <= 32'(w_m);
                    o_sat <= r_dq > w_lim;
                end
                r_mode <= M_IDLE;
            end else if (r_mode == M_DIV) begin
                r_cnt <= r_cnt - 7'd1;
                if (w_sh[85:0] >= 86'(i_n) || w_sh[86]) begin
                    r_rem <= 86'(w_sh - 87'(i_n));
                    r_quo <= {r_quo[84:0], 1'b1};
                end else begin
                    r_rem <= w_sh[85:0];
                    r_quo <= {r_quo[84:0], 1'b0};
                end
            end else if (r_mode == M_ROOT) begin
                // Restoring root: two radicand bits per step, taken from r_quo.
                r_cnt <= r_cnt - 7'd1;
                r_quo <= {r_quo[83:0], 2'b00};
                if (w_st >= {44'd0, r_sd, 2'b01}) begin
                    r_srem <= 88'(w_st - {44'd0, r_sd, 2'b01});
                    r_sd   <= {r_sd[42:0], 1'b1};
                end else begin
                    r_srem <= w_st[87:0];
                    r_sd   <= {r_sd[42:0], 1'b0};
                end
            end else if (r_mode == M_ZDIV) begin
                r_cnt <= r_cnt - 7'd1;
                if (w_dt >= 69'(r_sd)) begin
                    r_drem <= 68'(w_dt - 69'(r_sd));
                    r_dq   <= {r_dq[55:0], 1'b1};
                end else begin
                    r_drem <= w_dt[67:0];
                    r_dq   <= {r_dq[55:0], 1'b0};
                end
            end
        end
    end

    assign o_stat.busy    = (r_mode != M_IDLE) || r_sqv;
    assign o_stat.sd_zero = (r_sd == '0);
    assign o_z = r_neg ? 24'(-r_mag) : 24'(r_mag);
endmodule

// ===== sv/zsn_ctrl.sv =====
// Controller state machine sequencing load, statistics and output phases.
module zsn_ctrl import zsn_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    zsn_in_if.sink        s_in,
    output t_cmd          o_cmd,
    output logic [CW-1:0] o_n,
    input  t_stat         i_stat,
    output logic          o_valid,
    input  logic          i_ready,
    output logic          o_last
);
    localparam logic [3:0] S_LOAD = 4'd0, S_MEAN = 4'd1, S_MW = 4'd2, S_SSQ = 4'd3,
        S_SW = 4'd4, S_VAR = 4'd5, S_VW = 4'd6, S_SQ = 4'd7, S_QW = 4'd8,
        S_RD = 4'd9, S_DIV = 4'd10, S_DW = 4'd11, S_OUT = 4'd12;

    logic [3:0]    r_st;
    logic [CW-1:0] r_n;
    logic [CW-1:0] r_i;
    logic          w_acc;

    assign s_in.ready = (r_st == S_LOAD);
    assign w_acc = s_in.valid && s_in.ready;
    assign o_n = r_n;
    assign o_valid = (r_st == S_OUT);
    assign o_last = (r_i + 1'b1 == r_n);

    always_comb begin
        o_cmd.load  = w_acc;
        o_cmd.start = 1'b0;
        o_cmd.op    = C_NONE;
        o_cmd.addr  = r_i[AW-1:0];
        case (r_st)
            S_LOAD: o_cmd.addr = r_n[AW-1:0];
            S_MEAN: begin o_cmd.op = C_MEAN; o_cmd.start = 1'b1; end
            S_MW:   o_cmd.op = C_MEAN;
            S_SSQ:  begin o_cmd.op = C_SSQ; o_cmd.start = (r_i == '0); end
            S_SW:   o_cmd.op = C_SSQ;
            S_VAR:  begin o_cmd.op = C_VAR; o_cmd.start = !i_stat.busy; end
            S_SQ:   begin o_cmd.op = C_SQRT; o_cmd.start = 1'b1; end
            S_RD:   o_cmd.op = C_RD;
            S_DIV:  begin o_cmd.op = C_DIV; o_cmd.start = 1'b1; end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_LOAD;
            r_n  <= '0;
            r_i  <= '0;
        end else begin
            case (r_st)
                S_LOAD: if (w_acc) begin
                    r_n <= r_n + 1'b1;
                    if (s_in.last || r_n + 1'b1 == CW'(MAX_SAMPLES)) begin
                        r_st <= S_MEAN;
                    end
                end
                S_MEAN: r_st <= S_MW;
                S_MW: if (!i_stat.busy) begin
                    r_st <= S_SSQ;
                    r_i  <= '0;
                end
                S_SSQ: begin
                    // Reads one address ahead; the memory read data is registered.
                    r_i  <= 1'b1;
                    r_st <= S_SW;
                end
                S_SW: begin
                    r_i <= r_i + 1'b1;
                    if (r_i == r_n) begin
                        r_st <= S_VAR;
                    end
                end
                S_VAR: if (!i_stat.busy) r_st <= S_VW;
                S_VW: if (!i_stat.busy) r_st <= S_SQ;
                S_SQ: r_st <= S_QW;
                S_QW: if (!i_stat.busy) begin
                    r_st <= S_RD;
                    r_i  <= '0;
                end
                S_RD: r_st <= S_DIV;
                S_DIV: r_st <= S_DW;
                S_DW: if (!i_stat.busy) r_st <= S_OUT;
                S_OUT: if (i_ready) begin
                    if (o_last) begin
                        r_st <= S_LOAD;
                        r_n  <= '0;
                        r_i  <= '0;
                    end else begin
                        r_i  <= r_i + 1'b1;
                        r_st <= S_RD;
                    end
                end
                default: r_st <= S_LOAD;
            endcase
        end
    end

    ap_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_SAMPLES)) else $error("count overflow");
    ap_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |-> r_i < r_n) else $error("index past count");
    ap_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !s_in.ready) else $error("load during output");
endmodule

// ===== sv/zscore_normalize_core.sv =====
// Top level of the population z-score normalizer.
// Input words carry a signed Q16.16 sample and a last flag; up to 64 are
// stored. A word with last set, or the 64th word, closes the set. The block
// then computes mean (38-step divide), squared deviations (one per cycle
// from the sample memory), variance (86-step divide) and a 43-step square
// root. Each result word then takes a memory read and a 57-step divide,
// bit-serial; the next word starts only once the previous one is taken.
// Results leave in load order as signed Q8.16, with last_out on the final
// word, flat_set when the standard deviation is zero and saturated when clipped.
// Input ready is low from set close until the last result is taken.
// A stalled receiver holds the result word steady until ready rises.
// Synchronous reset empties the set; memory contents need no clearing.
module zscore_normalize_core import zsn_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    zsn_in_if.sink    s_in,
    zsn_out_if.source m_out
);
    t_cmd          w_cmd;
    t_stat         w_stat;
    logic [CW-1:0] w_n;
    logic [23:0]   w_z;
    logic          w_sat;

    zsn_ctrl u_ctrl (
        .i_clk, .i_rst_n, .s_in, .o_cmd(w_cmd), .o_n(w_n), .i_stat(w_stat),
        .o_valid(m_out.valid), .i_ready(m_out.ready), .o_last(m_out.last_out)
    );

    zsn_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_sample(s_in.sample), .i_n(w_n),
        .o_stat(w_stat), .o_z(w_z), .o_sat(w_sat)
    );

    assign m_out.flat_set  = w_stat.sd_zero;
    assign m_out.z_score   = w_stat.sd_zero ? 24'd0 : w_z;
    assign m_out.saturated = w_stat.sd_zero ? 1'b0 : w_sat;
endmodule

// ===== tb/zscore_normalize_core_test.sv =====
// Self-checking testbench for the z-score normalizer: driver, monitor and set predictor.
module zscore_normalize_core_test import zsn_pkg::*;;

    typedef struct {
        logic [31:0] sample;
        logic        last;
        int          gap;
    } t_word_in;

    typedef struct {
        logic [23:0] z_score;
        logic        last_out;
        logic        flat_set;
        logic        saturated;
    } t_word_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    zsn_in_if  s_in ();
    zsn_out_if m_out ();

    zscore_normalize_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_word_in    pending_words[$];
    t_word_out   expected_z[$];
    logic signed [31:0] set_samples[$];
    logic signed [37:0] set_sum;
    int          errors = 0;
    int          cycles = 0;
    int          hold_cycles = 0;
    int          stall_mode = 0;
    bit          stim_done = 0;
    int          gap_left = 0;
    bit          in_taken = 0;

    // Computes the z-scores of the set closed by the current word.
    task automatic close_set_predict();
        int n;
        logic signed [37:0] mean;
        logic signed [38:0] dev;
        logic [38:0] mag;
        logic [79:0] ssq;
        logic [95:0] var_q;
        logic [47:0] sd;
        logic [47:0] cand;
        logic [95:0] num;
        logic [95:0] m;
        logic [95:0] lim;
        t_word_out w;
        n = set_samples.size();
        mean = set_sum / n;
        if ((set_sum % n) != 0 && set_sum < 0) mean = mean - 1;
        ssq = '0;
        foreach (set_samples[i]) begin
            dev = 39'(set_samples[i]) - 39'(mean);
            mag = dev[38] ? 39'(-dev) : 39'(dev);
            ssq = ssq + 80'(mag) * 80'(mag);
        end
        var_q = (96'(ssq) << 16) / n;
        sd = '0;
        for (int b = 43; b >= 0; b--) begin
            cand = sd | (48'd1 << b);
            if (96'(cand) * 96'(cand) <= var_q) sd = cand;
        end
        foreach (set_samples[i]) begin
            w.z_score = '0;
            w.saturated = 1'b0;
            w.flat_set = (sd == 0);
            w.last_out = (i == n - 1);
            if (sd != 0) begin
                dev = 39'(set_samples[i]) - 39'(mean);
                mag = dev[38] ? 39'(-dev) : 39'(dev);
                num = (96'(mag) << 24) + 96'(sd >> 1);
                m = num / 96'(sd);
                lim = dev[38] ? 96'(1 << 23) : 96'((1 << 23) - 1);
                if (m > lim) begin
                    m = lim;
                    w.saturated = 1'b1;
                end
                w.z_score = dev[38] ? 24'(-m) : 24'(m);
            end
            expected_z.push_back(w);
        end
        set_samples.delete();
        set_sum = '0;
    endtask

    task automatic push_word(logic [31:0] s, logic l, int g);
        t_word_in w;
        w.sample = s;
        w.last = l;
        w.gap = g;
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] rand_sample(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    // Driver: offers words in bursts separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_in.valid <= 1'b0;
        end else if (s_in.valid && !in_taken) begin
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_in.valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].gap < 0 && expected_z.size() > 0)) begin
            s_in.valid <= 1'b1;
            s_in.sample <= pending_words[0].sample;
            s_in.last <= pending_words[0].last;
            gap_left <= pending_words[0].gap > 0 ? pending_words[0].gap : 0;
            void'(pending_words.pop_front());
        end else begin
            s_in.valid <= 1'b0;
        end
    end

    // Receiver ready pattern, with one long hold-off.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_out.ready <= 1'b0;
        end else if (cycles == 3000) begin
            hold_cycles <= 4000;
            m_out.ready <= 1'b0;
        end else begin
            if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0: m_out.ready <= 1'b1;
                1: m_out.ready <= $urandom_range(0, 1);
                2: m_out.ready <= ($urandom_range(0, 9) == 0);
                default: m_out.ready <= (cycles % 7) < 4;
            endcase
        end
    end

    // Monitor: predicts on accepted input words, checks accepted results.
    always @(posedge i_clk) begin
        t_word_out e;
        cycles <= cycles + 1;
        in_taken <= i_rst_n && s_in.valid && s_in.ready;
        if (i_rst_n) begin
            if (s_in.valid && s_in.ready) begin
                set_samples.push_back($signed(s_in.sample));
                set_sum = set_sum + 38'($signed(s_in.sample));
                if (s_in.last || set_samples.size() >= MAX_SAMPLES) close_set_predict();
            end
            if (m_out.valid && m_out.ready) begin
                if (expected_z.size() == 0) begin
                    $error("unexpected result word z_score=%h", m_out.z_score);
                    errors++;
                end else begin
                    e = expected_z.pop_front();
                    if (m_out.z_score !== e.z_score) begin
                        $error("z_score expected %h actual %h", e.z_score, m_out.z_score);
                        errors++;
                    end
                    if (m_out.last_out !== e.last_out) begin
                        $error("last_out expected %b actual %b", e.last_out, m_out.last_out);
                        errors++;
                    end
                    if (m_out.flat_set !== e.flat_set) begin
                        $error("flat_set expected %b actual %b", e.flat_set, m_out.flat_set);
                        errors++;
                    end
                    if (m_out.saturated !== e.saturated) begin
                        $error("saturated expected %b actual %b", e.saturated,
                               m_out.saturated);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        int len;
        int kind;
        s_in.valid = 1'b0;
        s_in.sample = '0;
        s_in.last = 1'b0;
        m_out.ready = 1'b0;
        set_sum = '0;
        // Single sample, flat set, extreme values, full store.
        push_word(32'h0001_0000, 1'b1, 0);
        push_word(32'h0005_0000, 1'b0, 0);
        push_word(32'h0005_0000, 1'b0, 1);
        push_word(32'h0005_0000, 1'b1, 0);
        push_word(32'h8000_0000, 1'b0, 0);
        push_word(32'h7FFF_FFFF, 1'b1, 2);
        push_word(32'h8000_0000, 1'b0, 0);
        push_word(32'h8000_0000, 1'b1, -1);
        for (int i = 0; i < 15; i++) push_word(32'd0, 1'b0, 0);
        push_word(32'h0100_0000, 1'b1, 0);
        push_word(32'hFFFF_FFFF, 1'b0, 0);
        push_word(32'h0000_0001, 1'b1, 0);
        for (int i = 0; i < MAX_SAMPLES; i++) push_word($urandom(), 1'b0, 0);
        while (pending_words.size() < 218) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
            kind = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
                push_word(rand_sample(kind), (i == len - 1),
                          $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0);
        end
        push_word(32'h1234_5678, 1'b0, -1);
        push_word(32'hEDCB_A987, 1'b1, 0);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_words.size() == 0 && !s_in.valid && expected_z.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_z.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        wait (cycles >= 1000000);
        $display("Regression FAIL");
        $finish;
    end
endmodule
